// ===== src/tfsf_pkg.sv =====
// shared types, constants and station table for the track first station finder
// no dependencies

package tfsf_pkg;

    localparam int NUM_STATIONS_DEF = 42;
    localparam int TABLE_LEN        = 42;
    localparam int IDX_W            = 6;
    localparam int RAD_W            = 12;
    localparam int CFG_IDX_W        = 4;
    localparam int ACC_W            = 81;
    localparam int OP_W             = 4;

    localparam logic signed [10:0] NO_HIT_Z = -11'sd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_INNER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER = CFG_IDX_W'(1);

    localparam logic [RAD_W-1:0] INNER_RESET = RAD_W'(131);
    localparam logic [RAD_W-1:0] OUTER_RESET = RAD_W'(670);

    localparam logic signed [10:0] STATION_MM [TABLE_LEN] = '{
        -11'sd175, -11'sd160, -11'sd145, -11'sd130, -11'sd115, -11'sd100,
        -11'sd85,  -11'sd70,  -11'sd55,  -11'sd40,  -11'sd25,  -11'sd10,
        11'sd5,    11'sd20,   11'sd35,   11'sd50,   11'sd65,   11'sd80,
        11'sd95,   11'sd110,  11'sd125,  11'sd140,  11'sd155,  11'sd170,
        11'sd185,  11'sd200,  11'sd215,  11'sd230,  11'sd245,  11'sd260,
        11'sd275,  11'sd290,  11'sd435,  11'sd450,  11'sd585,  11'sd600,
        11'sd635,  11'sd650,  11'sd685,  11'sd700,  11'sd735,  11'sd750
    };

    // datapath operations
    localparam logic [OP_W-1:0] OP_IDLE = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
    localparam logic [OP_W-1:0] OP_SU0  = 4'd2;
    localparam logic [OP_W-1:0] OP_SU1  = 4'd3;
    localparam logic [OP_W-1:0] OP_SU2  = 4'd4;
    localparam logic [OP_W-1:0] OP_SU3  = 4'd5;
    localparam logic [OP_W-1:0] OP_SU4  = 4'd6;
    localparam logic [OP_W-1:0] OP_DZ   = 4'd7;
    localparam logic [OP_W-1:0] OP_PD   = 4'd8;
    localparam logic [OP_W-1:0] OP_ABS  = 4'd9;
    localparam logic [OP_W-1:0] OP_SQ0  = 4'd10;
    localparam logic [OP_W-1:0] OP_SQ1  = 4'd11;
    localparam logic [OP_W-1:0] OP_SQ2  = 4'd12;
    localparam logic [OP_W-1:0] OP_OUT  = 4'd13;

    typedef struct packed {
        logic signed [23:0] mom_x;
        logic signed [23:0] mom_y;
        logic signed [23:0] mom_z;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } t_in_item;

    typedef struct packed {
        logic signed [10:0] hit_z;
        logic               hit_found;
        logic [5:0]         hit_station;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [RAD_W-1:0]     value;
    } t_cfg_wr;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic             found;
    } t_dp_cmd;

    typedef struct packed {
        logic pz_zero;
        logic dz_neg;
        logic hit;
    } t_dp_sts;

endpackage

// ===== src/tfsf_stream_if.sv =====
// valid/ready channel carrying one item of a generic payload type
// no dependencies

interface tfsf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tfsf_cfg_regs.sv =====
// acceptance radius registers written through the configuration channel
// depends on tfsf_pkg

module tfsf_cfg_regs import tfsf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [RAD_W-1:0]     i_wr_value,
    output logic [RAD_W-1:0]     o_inner_radius,
    output logic [RAD_W-1:0]     o_outer_radius
);

    logic [RAD_W-1:0] r_inner;
    logic [RAD_W-1:0] r_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= INNER_RESET;
            r_outer <= OUTER_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_INNER: r_inner <= i_wr_value;
                CFG_OUTER: r_outer <= i_wr_value;
                default: ;
            endcase
        end
    end

    assign o_inner_radius = r_inner;
    assign o_outer_radius = r_outer;

endmodule

// ===== src/tfsf_ctrl.sv =====
// controller: setup sequence, station scan and result hand-off
// depends on tfsf_pkg

module tfsf_ctrl import tfsf_pkg::*; #(
    parameter int NUM_STATIONS = NUM_STATIONS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam int SCAN_LEN = (NUM_STATIONS < TABLE_LEN) ? NUM_STATIONS : TABLE_LEN;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LEN - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SU0  = 4'd1;
    localparam logic [3:0] S_SU1  = 4'd2;
    localparam logic [3:0] S_SU2  = 4'd3;
    localparam logic [3:0] S_SU3  = 4'd4;
    localparam logic [3:0] S_SU4  = 4'd5;
    localparam logic [3:0] S_DZ   = 4'd6;
    localparam logic [3:0] S_PD   = 4'd7;
    localparam logic [3:0] S_ABS  = 4'd8;
    localparam logic [3:0] S_SQ0  = 4'd9;
    localparam logic [3:0] S_SQ1  = 4'd10;
    localparam logic [3:0] S_SQ2  = 4'd11;
    localparam logic [3:0] S_CMP  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_found, n_found;
    logic             r_out_valid, n_out_valid;
    logic [OP_W-1:0]  w_op;
    logic             w_in_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        w_op        = OP_IDLE;
        w_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_op    = OP_LOAD;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SU0;
                end
            end
            S_SU0: begin
                if (i_sts.pz_zero) begin
                    n_state = S_FIN;
                end else begin
                    w_op    = OP_SU0;
                    n_state = S_SU1;
                end
            end
            S_SU1: begin
                w_op    = OP_SU1;
                n_state = S_SU2;
            end
            S_SU2: begin
                w_op    = OP_SU2;
                n_state = S_SU3;
            end
            S_SU3: begin
                w_op    = OP_SU3;
                n_state = S_SU4;
            end
            S_SU4: begin
                w_op    = OP_SU4;
                n_state = S_DZ;
            end
            S_DZ: begin
                w_op    = OP_DZ;
                n_state = S_PD;
            end
            S_PD: begin
                if (i_sts.dz_neg) begin
                    // station upstream of the vertex
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DZ;
                    end
                end else begin
                    w_op    = OP_PD;
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                w_op    = OP_ABS;
                n_state = S_SQ0;
            end
            S_SQ0: begin
                w_op    = OP_SQ0;
                n_state = S_SQ1;
            end
            S_SQ1: begin
                w_op    = OP_SQ1;
                n_state = S_SQ2;
            end
            S_SQ2: begin
                w_op    = OP_SQ2;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    n_found = 1'b1;
                    n_state = S_FIN;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DZ;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_op        = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = w_op;
    assign o_cmd.idx   = r_idx;
    assign o_cmd.found = r_found;

endmodule

// ===== src/tfsf_dpath.sv =====
// datapath: two shared 25x25 multiplier lanes, bounds, station radius and result register
// depends on tfsf_pkg

module tfsf_dpath import tfsf_pkg::*; (
    input  logic             i_clk,
    input  t_dp_cmd          i_cmd,
    input  t_in_item         i_item,
    input  logic [RAD_W-1:0] i_inner_radius,
    input  logic [RAD_W-1:0] i_outer_radius,
    output t_dp_sts          o_sts,
    output t_out_item        o_result
);

    logic signed [23:0] r_px, r_py, r_pz;
    logic [23:0]        r_apz;
    logic signed [15:0] r_vx, r_vy, r_vz;
    logic signed [40:0] r_vxpz, r_vypz;
    logic [46:0]        r_pz2;
    logic [23:0]        r_ri2, r_ro2;
    logic [ACC_W-1:0]   r_lob, r_hib;
    logic signed [17:0] r_dz;
    logic signed [40:0] r_ax, r_ay;
    logic [39:0]        r_mx, r_my;
    logic [ACC_W-1:0]   r_acc;
    t_out_item          r_result;

    logic signed [24:0] w_a0, w_a1, w_b0, w_b1;
    logic signed [49:0] w_pa, w_pb;
    logic [23:0]        w_apz_in;
    logic signed [10:0] w_st_z;
    logic signed [17:0] w_dz;
    logic signed [40:0] w_nax, w_nay;
    logic [ACC_W-1:0]   w_sq_sum;

    assign w_apz_in = i_item.mom_z[23] ? (~i_item.mom_z + 24'd1) : i_item.mom_z;
    assign w_st_z   = STATION_MM[i_cmd.idx];
    assign w_dz     = {{3{w_st_z[10]}}, w_st_z, 4'b0000} - {{2{r_vz[15]}}, r_vz};
    assign w_nax    = 41'sd0 - r_ax;
    assign w_nay    = 41'sd0 - r_ay;

    // lane operand selection
    always_comb begin
        w_a0 = '0;
        w_a1 = '0;
        w_b0 = '0;
        w_b1 = '0;
        case (i_cmd.op)
            OP_SU0: begin
                w_a0 = {{9{r_vx[15]}}, r_vx};
                w_a1 = {r_pz[23], r_pz};
                w_b0 = {1'b0, r_apz};
                w_b1 = {1'b0, r_apz};
            end
            OP_SU1: begin
                w_a0 = {{9{r_vy[15]}}, r_vy};
                w_a1 = {r_pz[23], r_pz};
                w_b0 = {13'b0, i_inner_radius};
                w_b1 = {13'b0, i_inner_radius};
            end
            OP_SU2: begin
                w_a0 = {13'b0, i_outer_radius};
                w_a1 = {13'b0, i_outer_radius};
            end
            OP_SU3: begin
                w_a0 = {1'b0, r_pz2[23:0]};
                w_a1 = {1'b0, r_ri2};
                w_b0 = {1'b0, r_pz2[23:0]};
                w_b1 = {1'b0, r_ro2};
            end
            OP_SU4: begin
                w_a0 = {2'b0, r_pz2[46:24]};
                w_a1 = {1'b0, r_ri2};
                w_b0 = {2'b0, r_pz2[46:24]};
                w_b1 = {1'b0, r_ro2};
            end
            OP_PD: begin
                w_a0 = {r_px[23], r_px};
                w_a1 = {{7{r_dz[17]}}, r_dz};
                w_b0 = {r_py[23], r_py};
                w_b1 = {{7{r_dz[17]}}, r_dz};
            end
            OP_SQ0: begin
                w_a0 = {5'b0, r_mx[19:0]};
                w_a1 = {5'b0, r_mx[19:0]};
                w_b0 = {5'b0, r_my[19:0]};
                w_b1 = {5'b0, r_my[19:0]};
            end
            OP_SQ1: begin
                w_a0 = {5'b0, r_mx[19:0]};
                w_a1 = {5'b0, r_mx[39:20]};
                w_b0 = {5'b0, r_my[19:0]};
                w_b1 = {5'b0, r_my[39:20]};
            end
            OP_SQ2: begin
                w_a0 = {5'b0, r_mx[39:20]};
                w_a1 = {5'b0, r_mx[39:20]};
                w_b0 = {5'b0, r_my[39:20]};
                w_b1 = {5'b0, r_my[39:20]};
            end
            default: ;
        endcase
    end

    assign w_pa     = w_a0 * w_a1;
    assign w_pb     = w_b0 * w_b1;
    assign w_sq_sum = ACC_W'(w_pa[39:0]) + ACC_W'(w_pb[39:0]);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_px  <= i_item.mom_x;
                r_py  <= i_item.mom_y;
                r_pz  <= i_item.mom_z;
                r_apz <= w_apz_in;
                r_vx  <= i_item.vertex_x;
                r_vy  <= i_item.vertex_y;
                r_vz  <= i_item.vertex_z;
            end
            OP_SU0: begin
                r_vxpz <= w_pa[40:0];
                r_pz2  <= w_pb[46:0];
            end
            OP_SU1: begin
                r_vypz <= w_pa[40:0];
                r_ri2  <= w_pb[23:0];
            end
            OP_SU2: begin
                r_ro2 <= w_pa[23:0];
            end
            OP_SU3: begin
                r_lob <= ACC_W'(w_pa[47:0]);
                r_hib <= ACC_W'(w_pb[47:0]);
            end
            OP_SU4: begin
                r_lob <= r_lob + (ACC_W'(w_pa[46:0]) << 24);
                r_hib <= r_hib + (ACC_W'(w_pb[46:0]) << 24);
            end
            OP_DZ: begin
                r_dz <= w_dz;
            end
            OP_PD: begin
                r_ax <= r_vxpz + w_pa[40:0];
                r_ay <= r_vypz + w_pb[40:0];
            end
            OP_ABS: begin
                r_mx <= r_ax[40] ? w_nax[39:0] : r_ax[39:0];
                r_my <= r_ay[40] ? w_nay[39:0] : r_ay[39:0];
            end
            OP_SQ0: begin
                r_acc <= w_sq_sum;
            end
            OP_SQ1: begin
                r_acc <= r_acc + (w_sq_sum << 21);
            end
            OP_SQ2: begin
                r_acc <= r_acc + (w_sq_sum << 40);
            end
            OP_OUT: begin
                r_result.hit_found   <= i_cmd.found;
                r_result.hit_station <= i_cmd.found ? i_cmd.idx : '0;
                r_result.hit_z       <= i_cmd.found ? w_st_z : NO_HIT_Z;
            end
            default: ;
        endcase
    end

    assign o_sts.pz_zero = (r_apz == 24'd0);
    assign o_sts.dz_neg  = r_dz[17];
    assign o_sts.hit     = (r_lob < r_acc) && (r_acc < r_hib);
    assign o_result      = r_result;

endmodule

// ===== src/track_first_station_finder.sv =====
// top level of the track first station finder
// depends on tfsf_pkg, tfsf_stream_if, tfsf_cfg_regs, tfsf_ctrl, tfsf_dpath
//
// i_item carries one track (momentum and origin vertex); o_result returns one item
// per track: z in mm of the first station whose radius lies strictly inside the
// annulus, its index and a found flag (-1000, 0, 0 when none). i_cfg writes the
// inner radius (index 0) and outer radius (index 1); it is always ready and other
// indexes are ignored.
// each track goes through setup and hand-off, plus a dz step for each station
// upstream of the vertex and dz, extrapolation, abs, split square and compare
// steps for each station tested, scanning the 42 stations in order up to the
// first hit. the two multiplier lanes are shared by the setup, the extrapolation
// and the split radius squares, so the station scan sets the rate; zero pz skips it.
// one track is worked on at a time; the next is taken once the previous result is
// in the output register, even while the receiver stalls it. a full output
// register holds the finished result until it is taken.
// reset restores the radii to 131 and 670 and empties the output register.

module track_first_station_finder import tfsf_pkg::*; #(
    parameter int NUM_STATIONS = NUM_STATIONS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfsf_stream_if.sink   i_item,
    tfsf_stream_if.sink   i_cfg,
    tfsf_stream_if.source o_result
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [RAD_W-1:0] w_inner;
    logic [RAD_W-1:0] w_outer;
    logic             w_in_ready;
    logic             w_out_valid;
    t_out_item        w_result;
    t_in_item         w_item;
    t_cfg_wr          w_cfg;

    assign w_item       = i_item.data;
    assign w_cfg        = i_cfg.data;
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = w_in_ready;

    tfsf_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (i_cfg.valid),
        .i_wr_index     (w_cfg.index),
        .i_wr_value     (w_cfg.value),
        .o_inner_radius (w_inner),
        .o_outer_radius (w_outer)
    );

    tfsf_ctrl #(
        .NUM_STATIONS (NUM_STATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tfsf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_item         (w_item),
        .i_inner_radius (w_inner),
        .i_outer_radius (w_outer),
        .o_sts          (w_sts),
        .o_result       (w_result)
    );

    assign o_result.valid = w_out_valid;
    assign o_result.data  = w_result;

endmodule

// ===== sim/station_hit_checker.sv =====
// checker for the track first station finder: watches the track, register and result channels
// predicts each result from its own copy of the radii and the station table in tfsf_pkg
// depends on tfsf_pkg

`timescale 1ns / 1ps

module station_hit_checker import tfsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    input  logic      i_item_ready,
    input  t_in_item  i_item_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_wr   i_cfg_data,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_out_item i_res_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic [RAD_W-1:0] inner_r;
    logic [RAD_W-1:0] outer_r;
    t_out_item        expected_hits [$];

    function automatic logic [127:0] magnitude(input longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic t_out_item first_station_hit(input t_in_item trk,
                                                    input logic [RAD_W-1:0] rin,
                                                    input logic [RAD_W-1:0] rout);
        t_out_item    res;
        longint       px, py, pz, vx, vy, vz, dz;
        logic [127:0] apz, lo_bound, hi_bound, ax, ay, r2;
        res.hit_z       = NO_HIT_Z;
        res.hit_found   = 1'b0;
        res.hit_station = '0;
        px = longint'($signed(trk.mom_x));
        py = longint'($signed(trk.mom_y));
        pz = longint'($signed(trk.mom_z));
        vx = longint'($signed(trk.vertex_x));
        vy = longint'($signed(trk.vertex_y));
        vz = longint'($signed(trk.vertex_z));
        if (pz != 0) begin
            apz      = magnitude(pz);
            lo_bound = apz * apz * 128'(rin) * 128'(rin);
            hi_bound = apz * apz * 128'(rout) * 128'(rout);
            for (int i = 0; i < NUM_STATIONS_DEF && i < TABLE_LEN && !res.hit_found; i++) begin
                dz = longint'(STATION_MM[i]) * 16 - vz;
                if (dz >= 0) begin
                    ax = magnitude(vx * pz + px * dz);
                    ay = magnitude(vy * pz + py * dz);
                    r2 = ax * ax + ay * ay;
                    if (lo_bound < r2 && r2 < hi_bound) begin
                        res.hit_z       = STATION_MM[i];
                        res.hit_found   = 1'b1;
                        res.hit_station = IDX_W'(i);
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            inner_r = INNER_RESET;
            outer_r = OUTER_RESET;
            expected_hits.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_INNER: inner_r = i_cfg_data.value;
                    CFG_OUTER: outer_r = i_cfg_data.value;
                    default: ;
                endcase
            end
            // older expectations go out before the item taken at this edge comes in
            if (i_res_valid && i_res_ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result, hit_z", 0, int'($signed(i_res_data.hit_z)));
                end else begin
                    want = expected_hits.pop_front();
                    if (i_res_data.hit_z !== want.hit_z)
                        report_mismatch("hit_z", int'($signed(want.hit_z)),
                                        int'($signed(i_res_data.hit_z)));
                    if (i_res_data.hit_found !== want.hit_found)
                        report_mismatch("hit_found", int'(want.hit_found),
                                        int'(i_res_data.hit_found));
                    if (i_res_data.hit_station !== want.hit_station)
                        report_mismatch("hit_station", int'(want.hit_station),
                                        int'(i_res_data.hit_station));
                end
            end
            if (i_item_valid && i_item_ready)
                expected_hits.push_back(first_station_hit(i_item_data, inner_r, outer_r));
        end
        o_pending = expected_hits.size();
    end

endmodule

// ===== sim/tb_track_first_station_finder.sv =====
// testbench top for the track first station finder: clock, reset, track and register stimulus
// with random idling on both channels; checking is done by station_hit_checker
// depends on tfsf_pkg, tfsf_stream_if, track_first_station_finder, station_hit_checker

`timescale 1ns / 1ps

module tb_track_first_station_finder import tfsf_pkg::*; ();

    localparam int HOLD_CYCLES  = 700;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_OUTER + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_req;
    int   fail_count;
    int   pending;

    tfsf_stream_if #(.T(t_in_item))  item_ch ();
    tfsf_stream_if #(.T(t_cfg_wr))   cfg_ch ();
    tfsf_stream_if #(.T(t_out_item)) res_ch ();

    track_first_station_finder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    station_hit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_ch.valid),
        .i_item_ready (item_ch.ready),
        .i_item_data  (item_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_data   (cfg_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side, with the long hold-off counted here
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_in_item track_of(input longint px, input longint py, input longint pz,
                                          input longint vx, input longint vy, input longint vz);
        t_in_item trk;
        trk.mom_x    = 24'(px);
        trk.mom_y    = 24'(py);
        trk.mom_z    = 24'(pz);
        trk.vertex_x = 16'(vx);
        trk.vertex_y = 16'(vy);
        trk.vertex_z = 16'(vz);
        return trk;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic t_in_item make_track(input logic [RAD_W-1:0] rin,
                                            input logic [RAD_W-1:0] rout);
        t_in_item trk;
        longint   reach, vx, vy, vz, dz, tx, ty, pz;
        int       st;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            // aim at a point inside reach of the annulus at some station
            reach = longint'((rout > rin) ? rout : rin) + 64;
            vz = longint'($urandom_range(5000)) - 4000;
            vx = longint'($urandom_range(400)) - 200;
            vy = longint'($urandom_range(400)) - 200;
            st = $urandom_range(TABLE_LEN - 1);
            dz = longint'(STATION_MM[st]) * 16 - vz;
            if (dz <= 0)
                dz = longint'(STATION_MM[TABLE_LEN-1]) * 16 - vz;
            tx = longint'($urandom_range(2 * reach)) - reach;
            ty = longint'($urandom_range(2 * reach)) - reach;
            pz = longint'($urandom_range(20'hFFFFF, 1));
            if ($urandom_range(1))
                pz = -pz;
            trk = track_of(clamp24((tx - vx) * pz / dz), clamp24((ty - vy) * pz / dz), pz,
                           vx, vy, vz);
        end else if (pick < 75) begin
            trk = track_of(longint'($urandom_range(8191)) - 4096,
                           longint'($urandom_range(8191)) - 4096,
                           longint'($urandom_range(131071)) - 65536,
                           longint'($urandom_range(2047)) - 1024,
                           longint'($urandom_range(2047)) - 1024,
                           longint'($urandom_range(8191)) - 4096);
        end else if (pick < 90) begin
            trk = t_in_item'({$urandom, $urandom, $urandom, $urandom});
        end else begin
            trk = t_in_item'({$urandom, $urandom, $urandom, $urandom});
            case ($urandom_range(2))
                0: trk.mom_z = '0;
                1: trk.vertex_z = 16'(longint'(STATION_MM[$urandom_range(TABLE_LEN - 1)]) * 16);
                default: trk.vertex_z = 16'(longint'($urandom_range(32767, 12001)));
            endcase
        end
        return trk;
    endfunction

    task automatic send_track(input t_in_item trk);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= trk;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAD_W-1:0] val);
        t_cfg_wr wr;
        wr.index = idx;
        wr.value = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= wr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [RAD_W-1:0] rin, input logic [RAD_W-1:0] rout,
                             input int count, input int s_pct, input int r_pct,
                             input bit with_hold);
        write_reg(CFG_INNER, rin);
        write_reg(CFG_OUTER, rout);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 2)
                hold_req = 1'b1;
            send_track(make_track(rin, rout));
        end
        drain_results();
    endtask

    initial begin
        logic [RAD_W-1:0] r_a;
        logic [RAD_W-1:0] r_b;
        i_rst_n       = 1'b0;
        hold_req      = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 52;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // an index past the two radii must leave them untouched
        write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)), RAD_W'($urandom));

        // directed tracks under the reset radii of 131 and 670
        send_track(track_of(0, 0, 0, 0, 0, 0));
        send_track(track_of(100, 0, 0, 300, 0, -2800));
        send_track(track_of(0, 0, 1, 300, 0, -2800));
        send_track(track_of(0, 0, 1, 300, 0, -2799));
        send_track(track_of(0, 0, 5, 131, 0, -2800));
        send_track(track_of(0, 0, 5, 670, 0, 0));
        send_track(track_of(0, 0, -7, 132, 0, 0));
        send_track(track_of(0, 0, 3, 0, 669, -32768));
        send_track(track_of(0, 0, 1, 400, 0, 12000));
        send_track(track_of(0, 0, 1, 400, 0, 12001));
        send_track(track_of(0, 0, 1, 400, 0, 32767));
        send_track(track_of(8388607, 8388607, 8388607, 32767, 32767, 32767));
        send_track(track_of(-8388608, -8388608, -8388608, -32768, -32768, -32768));
        send_track(track_of(1, 0, 16, 0, 0, -2800));
        send_track(track_of(-1, -1, -16, 0, 0, -2800));
        send_track(track_of(1000, -2000, 8388607, -100, 50, -1000));
        send_track(track_of(8388607, 0, 1, 0, 0, 0));
        send_track(track_of(0, -8388608, -1, 0, 0, -2800));
        drain_results();

        run_phase('0, '1, 150, 22, 52, 1'b1);
        run_phase('1, '0, 20, 22, 52, 1'b0);
        r_a = RAD_W'($urandom_range(300, 40));
        r_b = RAD_W'($urandom_range(2000, 400));
        run_phase(r_a, r_b, 150, 52, 22, 1'b0);
        run_phase(r_a, r_a, 20, 52, 22, 1'b0);
        run_phase(RAD_W'($urandom), RAD_W'($urandom), 40, 52, 22, 1'b0);
        run_phase(INNER_RESET, OUTER_RESET, 150, 0, 0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tfsf_pkg.sv
src/tfsf_stream_if.sv
src/tfsf_cfg_regs.sv
src/tfsf_ctrl.sv
src/tfsf_dpath.sv
src/track_first_station_finder.sv
sim/station_hit_checker.sv
sim/tb_track_first_station_finder.sv
